// ----- sv/pidc_pkg.sv -----
// Package: shared types and constants of the PID controller step.
package pidc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ErrW = 33;
  localparam int unsigned IntW = 24;
  localparam int unsigned PerW = 31;
  localparam int unsigned CfgIdxW = 2;

  localparam logic signed [IntW-1:0] IntegLimit = 24'sd6553600;
  localparam logic [PerW-1:0] PeriodReset = 31'd655;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROP   = 2'd0,
    CFG_INTEG  = 2'd1,
    CFG_DERIV  = 2'd2,
    CFG_PERIOD = 2'd3
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_TI,
    ST_MUL_INC,
    ST_DIV,
    ST_MUL_D,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [DataW-1:0] target_value;
    logic signed [DataW-1:0] measured_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] drive_value;
    logic signed [DataW-1:0] prop_term;
    logic signed [IntW-1:0]  integ_term;
    logic signed [DataW-1:0] deriv_term;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [DataW-1:0]   data;
  } cfg_item_t;

endpackage

// ----- sv/pidc_in_if.sv -----
// Interface: input item channel.
interface pidc_in_if;
  import pidc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/pidc_out_if.sv -----
// Interface: result item channel.
interface pidc_out_if;
  import pidc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/pidc_cfg_if.sv -----
// Interface: configuration write channel.
interface pidc_cfg_if;
  import pidc_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/pid_controller_step.sv -----
// Top level: bit-serial PID controller step with clamped integral.
//
//  channel | dir | payload                                      | transfer when
//  in_     | in  | target_value, measured_value                 | valid & ready
//  out_    | out | drive_value, prop_term, integ_term, deriv_term | valid & ready
//  cfg_    | in  | index, data                                  | valid & ready
//
// Each item runs four shift-add multiplies of 33 steps and one restoring divide of 49 steps, each
// after a load step, one bit a cycle; the multiplies share one adder, the divide has its own
// subtractor. The first step after reset skips the divide and the D multiply.
// Reset clears state, gains and sets the period to 655; first step has D = 0.
// A result waits in the output register; the next item is taken while it waits,
// and its own result holds in ST_OUT, with the input closed, until that transfer.
module pid_controller_step
  import pidc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pidc_in_if.sink    in_ch,
  pidc_out_if.source out_ch,
  pidc_cfg_if.sink   cfg_ch
);

  localparam int unsigned MagW = 33;           // operand magnitude width
  localparam int unsigned ProdW = 2 * MagW;    // product width
  localparam int unsigned DivW = MagW + 16;    // dividend width
  localparam int unsigned CntW = 6;

  // Configuration registers.
  logic signed [DataW-1:0] kp_r, ki_r, kd_r;
  logic [PerW-1:0] per_r;

  // Controller state.
  logic signed [IntW-1:0] acc_r;
  logic signed [ErrW-1:0] last_r;
  logic first_r;

  // Work registers.
  state_t state_r, state_nxt;
  logic signed [ErrW-1:0] err_r;
  logic signed [DataW-1:0] p_r, d_r;
  logic [CntW-1:0] cnt_r;

  // Serial multiplier: multiplicand fixed, multiplier shifted out LSB first.
  logic [MagW-1:0]  mcand_r;
  logic [ProdW-1:0] prod_r;   // {accumulator, multiplier}
  logic             neg_r;

  // Serial divider.
  logic [DivW-1:0] dvd_r;     // dividend shifting into remainder, quotient in
  logic [PerW:0]   rem_r;

  // Output register.
  logic      ovalid_r;
  out_item_t odata_r;

  logic [PerW-1:0] ts;
  assign ts = (per_r == '0) ? {{(PerW-1){1'b0}}, 1'b1} : per_r;

  function automatic logic [MagW-1:0] mag33(input logic signed [MagW-1:0] x);
    mag33 = x[MagW-1] ? MagW'(-x) : x;
  endfunction

  // Saturated Q16.16 result from a magnitude product.
  function automatic logic signed [DataW-1:0] fin(input logic [ProdW-1:0] pr,
                                                  input logic ng);
    logic [ProdW-17:0] m;
    m = pr[ProdW-1:16];
    if (ng) begin
      if (m > 50'd2147483648) fin = 32'sh8000_0000;
      else fin = DataW'(-m);
    end else begin
      if (m > 50'd2147483647) fin = 32'sh7fff_ffff;
      else fin = DataW'(m);
    end
  endfunction

  logic signed [DataW-1:0] mres;
  assign mres = fin(prod_r, neg_r);

  logic mul_done, div_done;
  assign mul_done = (cnt_r == CntW'(MagW));
  assign div_done = (cnt_r == CntW'(DivW));

  // Multiplier step and divider step.
  logic [MagW:0] madd;
  assign madd = {1'b0, prod_r[ProdW-1:MagW]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
  logic [PerW+1:0] rsh, rsub;
  assign rsh  = {rem_r, dvd_r[DivW-1]};
  assign rsub = rsh - {2'b0, ts};

  // Integral and sum arithmetic.
  logic signed [DataW:0] isum;
  logic signed [IntW-1:0] iclamp;
  logic signed [DataW+2:0] dsum;
  logic signed [DataW-1:0] dsat;
  assign isum = 33'(signed'(acc_r)) + 33'(mres);
  always_comb begin
    if (isum > 33'(IntegLimit)) iclamp = IntegLimit;
    else if (isum < -33'(IntegLimit)) iclamp = -IntegLimit;
    else iclamp = isum[IntW-1:0];
  end
  assign dsum = 35'(p_r) + 35'(acc_r) + 35'(d_r);
  always_comb begin
    if (dsum > 35'sd2147483647) dsat = 32'sh7fff_ffff;
    else if (dsum < -35'sd2147483648) dsat = 32'sh8000_0000;
    else dsat = dsum[DataW-1:0];
  end

  logic signed [ErrW:0] diff;
  assign diff = 34'(err_r) - 34'(last_r);

  // Divider quotient with sign and saturation.
  logic signed [DataW-1:0] qsat;
  logic dneg_r;
  always_comb begin
    if (dneg_r) qsat = (dvd_r > 49'd2147483648) ? 32'sh8000_0000 : DataW'(-dvd_r);
    else qsat = (dvd_r > 49'd2147483647) ? 32'sh7fff_ffff : DataW'(dvd_r);
  end

  logic in_fire, out_fire;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = ovalid_r && out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = odata_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_fire) state_nxt = ST_MUL_P;
      ST_MUL_P:   if (mul_done) state_nxt = ST_MUL_TI;
      ST_MUL_TI:  if (mul_done) state_nxt = ST_MUL_INC;
      ST_MUL_INC: if (mul_done) state_nxt = first_r ? ST_SUM : ST_DIV;
      ST_DIV:     if (div_done) state_nxt = ST_MUL_D;
      ST_MUL_D:   if (mul_done) state_nxt = ST_SUM;
      ST_SUM:     state_nxt = ST_OUT;
      ST_OUT:     if (!ovalid_r || out_fire) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Load a multiply of a (33-bit signed) by b (33-bit signed).
  function automatic logic [ProdW+MagW:0] mload(input logic signed [MagW-1:0] a,
                                                input logic signed [MagW-1:0] b);
    mload = {a[MagW-1] ^ b[MagW-1], mag33(a), {MagW{1'b0}}, mag33(b)};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kp_r <= '0;
      ki_r <= '0;
      kd_r <= '0;
      per_r <= PeriodReset;
      acc_r <= '0;
      last_r <= '0;
      first_r <= 1'b1;
      ovalid_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      // Take configuration writes.
      if (cfg_ch.valid) begin
        unique case (cfg_idx_t'(cfg_ch.data.index))
          CFG_PROP:   kp_r <= cfg_ch.data.data;
          CFG_INTEG:  ki_r <= cfg_ch.data.data;
          CFG_DERIV:  kd_r <= cfg_ch.data.data;
          CFG_PERIOD: per_r <= cfg_ch.data.data[PerW-1:0];
          default: ;
        endcase
      end
      // Raise the result valid when the output register frees up; drop it on transfer.
      if ((state_r == ST_OUT) && (!ovalid_r || out_fire)) ovalid_r <= 1'b1;
      else if (out_fire) ovalid_r <= 1'b0;
      cnt_r <= (state_r != state_nxt) ? '0 : cnt_r + 1'b1;

      unique case (state_r)
        ST_IDLE: if (in_fire) begin
          err_r <= 33'(in_ch.data.target_value) - 33'(in_ch.data.measured_value);
          {neg_r, mcand_r, prod_r} <= mload(33'(kp_r),
            33'(in_ch.data.target_value) - 33'(in_ch.data.measured_value));
        end
        ST_MUL_P, ST_MUL_TI, ST_MUL_INC, ST_MUL_D: begin
          if (!mul_done) begin
            prod_r <= {madd, prod_r[MagW-1:1]};
          end else if (state_r == ST_MUL_P) begin
            p_r <= mres;
            {neg_r, mcand_r, prod_r} <= mload(33'(ki_r), err_r);
          end else if (state_r == ST_MUL_TI) begin
            {neg_r, mcand_r, prod_r} <= mload(33'(mres), 33'({1'b0, ts}));
          end else if (state_r == ST_MUL_INC) begin
            acc_r <= iclamp;
            dneg_r <= diff[ErrW];
            dvd_r <= {(diff[ErrW] ? ErrW'(-diff) : diff[ErrW-1:0]), 16'b0};
            rem_r <= '0;
            d_r <= '0;
          end else begin
            d_r <= mres;
          end
        end
        ST_DIV: begin
          if (!div_done) begin
            if (!rsub[PerW+1]) begin
              rem_r <= rsub[PerW:0];
              dvd_r <= {dvd_r[DivW-2:0], 1'b1};
            end else begin
              rem_r <= rsh[PerW:0];
              dvd_r <= {dvd_r[DivW-2:0], 1'b0};
            end
          end else begin
            {neg_r, mcand_r, prod_r} <= mload(33'(kd_r), 33'(qsat));
          end
        end
        ST_SUM: begin
          last_r <= err_r;
          first_r <= 1'b0;
        end
        // Load the result only once the previous one has gone.
        ST_OUT: if (!ovalid_r || out_fire) begin
          odata_r.drive_value <= dsat;
          odata_r.prop_term <= p_r;
          odata_r.integ_term <= acc_r;
          odata_r.deriv_term <= d_r;
        end
        default: ;
      endcase
    end
  end

endmodule
